// ===== design/bca_pkg.sv =====
// Package: shared types, codes and constants of the bitmap chunk allocator.
`timescale 1ns / 1ps
package bca_pkg;

  localparam int unsigned MAX_CHUNKS_DEF = 1024;
  localparam int unsigned ADDR_W         = 48;
  localparam int unsigned BYTES_W        = 17;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned USED_W         = 11;
  localparam int unsigned SIZE_W         = 18;
  localparam int unsigned QUOT_W         = ADDR_W - 4;
  localparam int unsigned DIV_W          = SIZE_W - 4;
  localparam int unsigned DIV_STEPS      = QUOT_W;
  localparam int unsigned PADDR_W        = 5;
  localparam int unsigned PDATA_W        = 64;
  localparam int unsigned MDATA_W        = 64;

  localparam logic [7:0] FULL_ROW = 8'hff;

  localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
  localparam logic [BYTES_W-1:0] BYTES_RST = BYTES_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(1024);

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_BYTES = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_ADD,
    S_DIV,
    S_FREE_RD,
    S_FREE_UPD,
    S_OUT
  } bca_state_e;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic scan_step;
    logic mul;
    logic add;
    logic div_step;
    logic set_full;
    logic set_range;
    logic free_rd;
    logic free_upd;
    logic out_load;
  } bca_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_found;
    logic scan_empty;
    logic div_done;
    logic in_range;
  } bca_sts_t;

endpackage

// ===== design/bitmap_chunk_allocator.sv =====
// Top level: first-fit bitmap chunk allocator with register port and stream ports.
// Allocate: first-fit scan of one 8-chunk row per cycle, then a multiply and an add form the grant.
// Free: the 44-step restoring divider finds the chunk index, then its bitmap bit is read and cleared.
// One word in flight; the next word is taken while a result still waits on the output.
// Reset: registers return to defaults, then a clearing pass zeroes the bitmap with tready low;
// register writes are taken meanwhile.
`timescale 1ns / 1ps
module bitmap_chunk_allocator #(
  parameter int unsigned MAX_CHUNKS = bca_pkg::MAX_CHUNKS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bca_pkg::PADDR_W-1:0]  paddr,
  input  logic [bca_pkg::PDATA_W-1:0]  pwdata,
  output logic [bca_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [bca_pkg::ADDR_W-1:0]   s_axis_tdata_i,  // chunk_address
  input  logic                         s_axis_tuser_i,  // req_type
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [bca_pkg::MDATA_W-1:0]  m_axis_tdata_o   // status, granted_address, used_count
);

  logic [bca_pkg::ADDR_W-1:0]  base_q;
  logic [bca_pkg::BYTES_W-1:0] bytes_q;
  logic [bca_pkg::COUNT_W-1:0] count_q;
  logic                        cfg_wr;

  bca_pkg::bca_cmd_t           cmd;
  bca_pkg::bca_sts_t           sts;
  logic [1:0]                  status;
  logic [bca_pkg::ADDR_W-1:0]  grant;
  logic [bca_pkg::USED_W-1:0]  used;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= bca_pkg::BASE_RST;
      bytes_q <= bca_pkg::BYTES_RST;
      count_q <= bca_pkg::COUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:3])
        bca_pkg::REG_BASE:  base_q  <= pwdata[bca_pkg::ADDR_W-1:0];
        bca_pkg::REG_BYTES: bytes_q <= pwdata[bca_pkg::BYTES_W-1:0];
        bca_pkg::REG_COUNT: count_q <= pwdata[bca_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      bca_pkg::REG_BASE:  prdata = bca_pkg::PDATA_W'(base_q);
      bca_pkg::REG_BYTES: prdata = bca_pkg::PDATA_W'(bytes_q);
      bca_pkg::REG_COUNT: prdata = bca_pkg::PDATA_W'(count_q);
      default:            prdata = '0;
    endcase
  end

  bca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .req_type_i  (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bca_datapath #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .base_i   (base_q),
    .bytes_i  (bytes_q),
    .count_i  (count_q),
    .addr_i   (s_axis_tdata_i),
    .status_o (status),
    .grant_o  (grant),
    .used_o   (used)
  );

  assign m_axis_tdata_o = {3'b000, used, grant, status};

endmodule

// ===== design/bca_datapath.sv =====
// Datapath: bitmap memory, row scan, grant multiply-add, offset divider, result registers.
`timescale 1ns / 1ps
module bca_datapath #(
  parameter int unsigned MAX_CHUNKS = bca_pkg::MAX_CHUNKS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bca_pkg::bca_cmd_t                 cmd_i,
  output bca_pkg::bca_sts_t                 sts_o,
  input  logic [bca_pkg::ADDR_W-1:0]        base_i,
  input  logic [bca_pkg::BYTES_W-1:0]       bytes_i,
  input  logic [bca_pkg::COUNT_W-1:0]       count_i,
  input  logic [bca_pkg::ADDR_W-1:0]        addr_i,
  output logic [1:0]                        status_o,
  output logic [bca_pkg::ADDR_W-1:0]        grant_o,
  output logic [bca_pkg::USED_W-1:0]        used_o
);

  localparam int unsigned ROWS  = (MAX_CHUNKS + 7) / 8;
  localparam int unsigned CAP   = ROWS * 8;
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned IW    = RW + 3;
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned EW    = (CNT_W > 12) ? CNT_W : 12;
  localparam int unsigned MUL_W = IW + bca_pkg::SIZE_W;
  localparam int unsigned DCW   = $clog2(bca_pkg::DIV_STEPS + 1);

  logic [7:0] mem [ROWS];
  logic [7:0] rdata_q;

  logic [RW:0]                   row_q, row_d;
  logic                          pend_q, pend_d;
  logic [RW-1:0]                 prow_q;
  logic [IW-1:0]                 idx_q;
  logic [CNT_W-1:0]              used_q, used_d;
  logic [1:0]                    status_q;
  logic [bca_pkg::ADDR_W-1:0]    grant_q;
  logic [bca_pkg::ADDR_W-1:0]    prod_q;
  logic                          below_q;
  logic [bca_pkg::QUOT_W-1:0]    quo_q;
  logic [bca_pkg::DIV_W-1:0]     rem_q;
  logic [DCW-1:0]                dcnt_q;
  logic [1:0]                    out_status_q;
  logic [bca_pkg::ADDR_W-1:0]    out_grant_q;
  logic [bca_pkg::USED_W-1:0]    out_used_q;

  logic [bca_pkg::SIZE_W-1:0]    size_rnd, size_eff;
  logic [bca_pkg::DIV_W-1:0]     dvsr;
  logic [11:0]                   cnt_rnd;
  logic [EW-1:0]                 cnt_ext;
  logic [CNT_W-1:0]              cnt_eff;
  logic [RW:0]                   nrows;
  logic [2:0]                    zpos;
  logic                          found;
  logic [bca_pkg::ADDR_W-1:0]    offset;
  logic [bca_pkg::DIV_W:0]       rtry;
  logic                          rfit;
  logic [MUL_W-1:0]              mul;
  logic                          rd_en, wr_en;
  logic [RW-1:0]                 rd_addr, wr_addr;
  logic [7:0]                    wr_data;

  // effective chunk size and chunk count
  always_comb begin
    size_rnd = (bca_pkg::SIZE_W'(bytes_i) + bca_pkg::SIZE_W'(15)) & ~bca_pkg::SIZE_W'(15);
    size_eff = (size_rnd == '0) ? bca_pkg::SIZE_W'(16) : size_rnd;
    dvsr     = size_eff[bca_pkg::SIZE_W-1:4];
    cnt_rnd  = (12'(count_i) + 12'd7) & ~12'd7;
    cnt_ext  = (EW'(cnt_rnd) > EW'(CAP)) ? EW'(CAP) : EW'(cnt_rnd);
    cnt_eff  = CNT_W'(cnt_ext);
    nrows    = (RW + 1)'(cnt_eff >> 3);
  end

  always_comb begin
    zpos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!rdata_q[i]) zpos = 3'(i);
    end
  end

  assign found  = pend_q && (rdata_q != bca_pkg::FULL_ROW);
  assign offset = addr_i - base_i;
  assign rtry   = {rem_q, quo_q[bca_pkg::QUOT_W-1]};
  assign rfit   = rtry >= {1'b0, dvsr};
  assign mul    = MUL_W'(idx_q) * MUL_W'(size_eff);

  assign sts_o.clr_done   = (row_q == (RW + 1)'(ROWS - 1));
  assign sts_o.scan_found = found;
  assign sts_o.scan_empty = !found && (row_q >= nrows);
  assign sts_o.div_done   = (dcnt_q == DCW'(bca_pkg::DIV_STEPS));
  assign sts_o.in_range   = !below_q && (quo_q < bca_pkg::QUOT_W'(cnt_eff));

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = row_q[RW-1:0];
    wr_addr = row_q[RW-1:0];
    wr_data = 8'h00;
    row_d   = row_q;
    pend_d  = pend_q;
    used_d  = used_q;
    if (cmd_i.clr_step) begin
      wr_en = 1'b1;
      row_d = row_q + 1'b1;
    end
    if (cmd_i.load) begin
      row_d  = '0;
      pend_d = 1'b0;
    end
    if (cmd_i.scan_step) begin
      if (found) begin
        wr_en   = 1'b1;
        wr_addr = prow_q;
        wr_data = rdata_q | (8'd1 << zpos);
        used_d  = used_q + 1'b1;
        pend_d  = 1'b0;
      end else if (row_q < nrows) begin
        rd_en  = 1'b1;
        row_d  = row_q + 1'b1;
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
    end
    if (cmd_i.free_rd) begin
      rd_en   = 1'b1;
      rd_addr = quo_q[RW+2:3];
    end
    if (cmd_i.free_upd && rdata_q[quo_q[2:0]]) begin
      wr_en   = 1'b1;
      wr_addr = quo_q[RW+2:3];
      wr_data = rdata_q & ~(8'd1 << quo_q[2:0]);
      used_d  = used_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      pend_q <= 1'b0;
      used_q <= '0;
      dcnt_q <= '0;
    end else begin
      row_q  <= row_d;
      pend_q <= pend_d;
      used_q <= used_d;
      if (cmd_i.load) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en && cmd_i.scan_step) prow_q <= row_q[RW-1:0];
    if (cmd_i.scan_step && found) idx_q <= {prow_q, zpos};
    if (cmd_i.mul) prod_q <= bca_pkg::ADDR_W'(mul);
    if (cmd_i.load) begin
      status_q <= bca_pkg::STAT_OK;
      grant_q  <= '0;
      below_q  <= addr_i < base_i;
      quo_q    <= offset[bca_pkg::ADDR_W-1:4];
      rem_q    <= '0;
    end else begin
      if (cmd_i.add) grant_q <= base_i + prod_q;
      if (cmd_i.set_full) status_q <= bca_pkg::STAT_FULL;
      if (cmd_i.set_range) status_q <= bca_pkg::STAT_RANGE;
      if (cmd_i.div_step) begin
        rem_q <= rfit ? bca_pkg::DIV_W'(rtry - {1'b0, dvsr}) : bca_pkg::DIV_W'(rtry);
        quo_q <= {quo_q[bca_pkg::QUOT_W-2:0], rfit};
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      out_grant_q  <= grant_q;
      out_used_q   <= bca_pkg::USED_W'(used_q);
    end
  end

  assign status_o = out_status_q;
  assign grant_o  = out_grant_q;
  assign used_o   = out_used_q;

endmodule

// ===== design/bca_ctrl.sv =====
// Controller: sequencing state machine and stream handshakes.
`timescale 1ns / 1ps
module bca_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              req_type_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bca_pkg::bca_cmd_t cmd_o,
  input  bca_pkg::bca_sts_t sts_i
);

  bca_pkg::bca_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bca_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bca_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) state_d = bca_pkg::S_IDLE;
      end
      bca_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (req_type_i == bca_pkg::REQ_ALLOC) ? bca_pkg::S_SCAN : bca_pkg::S_DIV;
        end
      end
      bca_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_found) begin
          state_d = bca_pkg::S_MUL;
        end else if (sts_i.scan_empty) begin
          cmd_o.set_full = 1'b1;
          state_d = bca_pkg::S_OUT;
        end
      end
      bca_pkg::S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = bca_pkg::S_ADD;
      end
      bca_pkg::S_ADD: begin
        cmd_o.add = 1'b1;
        state_d = bca_pkg::S_OUT;
      end
      bca_pkg::S_DIV: begin
        if (!sts_i.div_done) begin
          cmd_o.div_step = 1'b1;
        end else if (sts_i.in_range) begin
          state_d = bca_pkg::S_FREE_RD;
        end else begin
          cmd_o.set_range = 1'b1;
          state_d = bca_pkg::S_OUT;
        end
      end
      bca_pkg::S_FREE_RD: begin
        cmd_o.free_rd = 1'b1;
        state_d = bca_pkg::S_FREE_UPD;
      end
      bca_pkg::S_FREE_UPD: begin
        cmd_o.free_upd = 1'b1;
        state_d = bca_pkg::S_OUT;
      end
      bca_pkg::S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = bca_pkg::S_IDLE;
        end
      end
      default: state_d = bca_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/bca_checker.sv =====
// Checker: port-level assertions for the allocator, bound to the top level.
`timescale 1ns / 1ps
module bca_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [bca_pkg::MDATA_W-1:0] m_axis_tdata_o
);

  // one word in flight: no new word right after one is taken
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("word accepted back to back");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1:0] <= bca_pkg::STAT_RANGE)
    else $error("undefined status code");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] != bca_pkg::STAT_OK) |->
      m_axis_tdata_o[49:2] == '0)
    else $error("nonzero address on failed request");

endmodule

bind bitmap_chunk_allocator bca_checker u_bca_checker (.*);

// ===== sim/tb_bitmap_chunk_allocator.sv =====
// Testbench: checks the bitmap chunk allocator against a built-in prediction of its results.
`timescale 1ns / 1ps
module tb_bitmap_chunk_allocator;

  localparam int unsigned NCHUNK = bca_pkg::MAX_CHUNKS_DEF;

  typedef struct packed {
    logic [1:0]                 status;
    logic [bca_pkg::ADDR_W-1:0] grant;
    logic [bca_pkg::USED_W-1:0] used;
  } chunk_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel, penable, pwrite;
  logic [bca_pkg::PADDR_W-1:0]  paddr;
  logic [bca_pkg::PDATA_W-1:0]  pwdata;
  logic [bca_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;
  logic                         s_axis_tvalid_i;
  logic                         s_axis_tready_o;
  logic [bca_pkg::ADDR_W-1:0]   s_axis_tdata_i;  // chunk_address
  logic                         s_axis_tuser_i;  // req_type
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i;
  logic [bca_pkg::MDATA_W-1:0]  m_axis_tdata_o;  // status, granted_address, used_count

  // allocator state as predicted
  logic [bca_pkg::ADDR_W-1:0]   cfg_base;
  logic [bca_pkg::BYTES_W-1:0]  cfg_bytes;
  logic [bca_pkg::COUNT_W-1:0]  cfg_count;
  logic [NCHUNK-1:0]            chunk_map;
  logic [bca_pkg::USED_W-1:0]   used_total;

  chunk_result_t                pending_results[$];
  logic [bca_pkg::ADDR_W-1:0]   live_chunks[$];
  int                           errors = 0;
  bit                           quiet = 1'b0;

  bitmap_chunk_allocator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return {16'h0, v[47:0]};
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] eff_size();
    logic [63:0] s;
    s = (64'(cfg_bytes) + 64'd15) & ~64'd15;
    return (s == 0) ? 64'd16 : s;
  endfunction

  function automatic logic [63:0] eff_count();
    logic [63:0] c;
    c = (64'(cfg_count) + 64'd7) & ~64'd7;
    return (c > NCHUNK) ? 64'(NCHUNK) : c;
  endfunction

  task automatic predict_allocation(input logic req, input logic [bca_pkg::ADDR_W-1:0] addr,
                                    output chunk_result_t r);
    logic [63:0] size, count, idx;
    bit found;
    size  = eff_size();
    count = eff_count();
    found = 1'b0;
    r     = '0;
    r.status = bca_pkg::STAT_OK;
    if (req == bca_pkg::REQ_ALLOC) begin
      for (idx = 0; idx < count && !found; idx++) begin
        if (!chunk_map[idx]) begin
          found          = 1'b1;
          chunk_map[idx] = 1'b1;
          used_total     = used_total + 1'b1;
          r.grant        = bca_pkg::ADDR_W'(64'(cfg_base) + idx * size);
        end
      end
      if (!found) r.status = bca_pkg::STAT_FULL;
    end else if (addr < cfg_base) begin
      r.status = bca_pkg::STAT_RANGE;
    end else begin
      idx = (64'(addr) - 64'(cfg_base)) / size;
      if (idx >= count) begin
        r.status = bca_pkg::STAT_RANGE;
      end else if (chunk_map[idx]) begin
        chunk_map[idx] = 1'b0;
        used_total     = used_total - 1'b1;
      end
    end
    r.used = used_total;
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bca_pkg::PADDR_W'({idx, 3'b000});
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      bca_pkg::REG_BASE:  cfg_base  = val[bca_pkg::ADDR_W-1:0];
      bca_pkg::REG_BYTES: cfg_bytes = val[bca_pkg::BYTES_W-1:0];
      bca_pkg::REG_COUNT: cfg_count = val[bca_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apb_check(input logic [1:0] idx, input logic [63:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= bca_pkg::PADDR_W'({idx, 3'b000});
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== want) report_mismatch($sformatf("register %0d readback", idx), prdata, want);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_word(input logic req, input logic [bca_pkg::ADDR_W-1:0] addr,
                           output chunk_result_t r);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= addr;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_allocation(req, addr, r);
    pending_results.push_back(r);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    wait (pending_results.size() == 0);
  endtask

  task automatic test_register_access();
    apb_write(bca_pkg::REG_BASE, '1);
    apb_write(bca_pkg::REG_BYTES, '1);
    apb_write(bca_pkg::REG_COUNT, '1);
    apb_check(bca_pkg::REG_BASE, 64'({bca_pkg::ADDR_W{1'b1}}));
    apb_check(bca_pkg::REG_BYTES, 64'({bca_pkg::BYTES_W{1'b1}}));
    apb_check(bca_pkg::REG_COUNT, 64'({bca_pkg::COUNT_W{1'b1}}));
    apb_write(bca_pkg::REG_BASE, 64'(bca_pkg::BASE_RST));
    apb_write(bca_pkg::REG_BYTES, 64'(bca_pkg::BYTES_RST));
    apb_write(bca_pkg::REG_COUNT, 64'(bca_pkg::COUNT_RST));
    apb_check(bca_pkg::REG_BASE, 64'(bca_pkg::BASE_RST));
    apb_check(bca_pkg::REG_BYTES, 64'(bca_pkg::BYTES_RST));
    apb_check(bca_pkg::REG_COUNT, 64'(bca_pkg::COUNT_RST));
  endtask

  // defaults: reuse, unaligned free, double free, index past count
  task automatic test_default_layout();
    chunk_result_t r;
    send_word(bca_pkg::REQ_ALLOC, '1, r);
    send_word(bca_pkg::REQ_ALLOC, '0, r);
    send_word(bca_pkg::REQ_ALLOC, 48'h5a5a, r);
    send_word(bca_pkg::REQ_FREE, 48'd16, r);
    send_word(bca_pkg::REQ_ALLOC, '0, r);
    send_word(bca_pkg::REQ_FREE, 48'd21, r);
    send_word(bca_pkg::REQ_FREE, 48'd16, r);
    send_word(bca_pkg::REQ_FREE, 48'd16384, r);
    send_word(bca_pkg::REQ_FREE, '1, r);
    drain();
  endtask

  // base near the top of the address space, zero size, tiny count
  task automatic test_wrap_and_tiny();
    chunk_result_t r;
    apb_write(bca_pkg::REG_BASE, 64'h0000_FFFF_FFFF_FFE0);
    apb_write(bca_pkg::REG_BYTES, 64'd0);
    apb_write(bca_pkg::REG_COUNT, 64'd1);
    send_word(bca_pkg::REQ_ALLOC, '0, r);
    send_word(bca_pkg::REQ_ALLOC, '0, r);
    send_word(bca_pkg::REQ_ALLOC, '0, r);
    send_word(bca_pkg::REQ_FREE, 48'd0, r);
    send_word(bca_pkg::REQ_FREE, 48'hFFFF_FFFF_FFF0, r);
    drain();
  endtask

  // no chunks at all, then largest size with the count saturated
  task automatic test_empty_and_saturated();
    chunk_result_t r;
    apb_write(bca_pkg::REG_COUNT, 64'd0);
    send_word(bca_pkg::REQ_ALLOC, '0, r);
    send_word(bca_pkg::REQ_FREE, 48'hFFFF_FFFF_FFE0, r);
    drain();
    apb_write(bca_pkg::REG_BASE, 64'd0);
    apb_write(bca_pkg::REG_BYTES, 64'h1_FFFF);
    apb_write(bca_pkg::REG_COUNT, 64'h7FF);
    send_word(bca_pkg::REQ_ALLOC, '0, r);
    send_word(bca_pkg::REQ_FREE, '1, r);
    send_word(bca_pkg::REQ_FREE, 48'(64'd1023 * 64'd131072 + 64'd5), r);
    send_word(bca_pkg::REQ_ALLOC, '0, r);
    drain();
  endtask

  task automatic test_random_traffic();
    chunk_result_t r;
    logic [63:0]   a, size, count;
    logic          req;
    int            k, sel;
    for (int p = 0; p < 8; p++) begin
      sel = $urandom_range(0, 3);
      a = (sel == 0) ? 64'd0 :
          (sel == 1) ? rand48() :
          (sel == 2) ? 64'h0000_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1 << 20)) :
                       64'($urandom);
      apb_write(bca_pkg::REG_BASE, a);
      sel = $urandom_range(0, 4);
      a = (sel == 0) ? 64'd0 :
          (sel == 1) ? 64'd16 :
          (sel == 2) ? 64'($urandom_range(1, 4096)) :
          (sel == 3) ? 64'($urandom_range(1, 65536)) : 64'h1_FFFF;
      apb_write(bca_pkg::REG_BYTES, a);
      sel = $urandom_range(0, 9);
      a = (sel == 0) ? 64'd0 :
          (sel < 5)  ? 64'($urandom_range(1, 24)) :
          (sel < 8)  ? 64'($urandom_range(1, 160)) : 64'($urandom_range(1, 2047));
      apb_write(bca_pkg::REG_COUNT, a);
      size  = eff_size();
      count = eff_count();
      live_chunks.delete();
      quiet = (p == 3 || p == 6);
      for (int n = 0; n < 150; n++) begin
        if (n % 60 == 59) drain();
        req = ($urandom_range(0, 99) < 50) ? bca_pkg::REQ_ALLOC : bca_pkg::REQ_FREE;
        a   = rand48();
        if (req == bca_pkg::REQ_FREE) begin
          sel = $urandom_range(0, 99);
          if (sel < 55 && live_chunks.size() > 0) begin
            k = $urandom_range(0, live_chunks.size() - 1);
            a = 64'(live_chunks[k]);
            live_chunks.delete(k);
            if ($urandom_range(0, 3) == 0) a = a + 64'($urandom_range(0, int'(size) - 1));
          end else if (sel < 72) begin
            a = 64'(cfg_base) + 64'($urandom_range(0, int'(count) + 8)) * size;
          end else if (sel < 82) begin
            a = 64'(cfg_base) - 64'($urandom_range(1, 64));
          end
        end
        send_word(req, a[bca_pkg::ADDR_W-1:0], r);
        if (req == bca_pkg::REQ_ALLOC && r.status == bca_pkg::STAT_OK)
          live_chunks.push_back(r.grant);
        pause_sender(gap_len());
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  // result side: random backpressure
  initial begin
    int run;
    m_axis_tready_i = 1'b0;
    forever begin
      run = $urandom_range(1, 16);
      @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
      repeat (run - 1) @(negedge clk_i);
      run = gap_len();
      if (run > 0) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
        repeat (run - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    chunk_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing expected", m_axis_tdata_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[1:0] !== want.status)
          report_mismatch("status", m_axis_tdata_o[1:0], want.status);
        if (m_axis_tdata_o[49:2] !== want.grant)
          report_mismatch("granted_address", m_axis_tdata_o[49:2], want.grant);
        if (m_axis_tdata_o[60:50] !== want.used)
          report_mismatch("used_count", m_axis_tdata_o[60:50], want.used);
      end
    end
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = bca_pkg::REQ_ALLOC;
    s_axis_tdata_i  = '0;
    cfg_base        = bca_pkg::BASE_RST;
    cfg_bytes       = bca_pkg::BYTES_RST;
    cfg_count       = bca_pkg::COUNT_RST;
    chunk_map       = '0;
    used_total      = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_access();
    test_default_layout();
    test_wrap_and_tiny();
    test_empty_and_saturated();
    test_random_traffic();

    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
